// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the drive command block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GDC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define GDC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gdc_pkg.sv =====
`timescale 1ns / 1ps

package gdc_pkg;

  // Configuration register file
  localparam int unsigned CfgW    = 15;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED_LOW  = 2'd0,
    CFG_SPEED_MID  = 2'd1,
    CFG_SPEED_HIGH = 2'd2,
    CFG_TURN_LIMIT = 2'd3
  } cfg_idx_e;

  localparam logic [CfgW-1:0] SPEED_LOW_RST  = 15'd128;
  localparam logic [CfgW-1:0] SPEED_MID_RST  = 15'd256;
  localparam logic [CfgW-1:0] SPEED_HIGH_RST = 15'd512;
  localparam logic [CfgW-1:0] TURN_LIMIT_RST = 15'd256;

  // Button codes
  localparam logic [7:0] KEY_NONE      = 8'd0;
  localparam logic [7:0] KEY_GEAR_UP   = 8'd5;
  localparam logic [7:0] KEY_GEAR_DOWN = 8'd7;
  localparam logic [7:0] KEY_SERIAL    = 8'd9;
  localparam logic [7:0] KEY_PAD       = 8'd10;
  localparam logic [7:0] KEY_ENABLE    = 8'd13;
  localparam logic [7:0] KEY_BRAKE     = 8'd14;
  localparam logic [7:0] KEY_SHUTDOWN  = 8'd16;

  // Stick centers, dead bands and shutdown signatures
  localparam logic [7:0] LEFT_CENTER  = 8'd128;
  localparam logic [7:0] RIGHT_CENTER = 8'd127;
  localparam logic [7:0] LEFT_DB_LO   = 8'd108;
  localparam logic [7:0] LEFT_DB_HI   = 8'd148;
  localparam logic [7:0] RIGHT_DB_LO  = 8'd107;
  localparam logic [7:0] RIGHT_DB_HI  = 8'd147;
  localparam logic [7:0] STICK_FULL   = 8'd255;
  localparam logic [7:0] STICK_MID    = 8'd128;

  localparam logic [1:0] GEAR_MIN = 2'd0;
  localparam logic [1:0] GEAR_MID = 2'd1;
  localparam logic [1:0] GEAR_MAX = 2'd2;

  // Scaled magnitude: 15-bit limit times 8-bit stick offset
  localparam int unsigned MagW = CfgW + 8;
  // floor(m/127) == (m * RECIP127) >> RECIP_SHIFT for every m < 2**MagW
  localparam int unsigned RecipW      = 24;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam logic [RecipW-1:0] RECIP127 = 24'd8454661;

  typedef enum logic [2:0] {
    LED_NONE         = 3'd0,
    LED_SERIAL_BLINK = 3'd1,
    LED_PAD_BLINK    = 3'd2,
    LED_GREEN        = 3'd3,
    LED_RED          = 3'd4,
    LED_PINK         = 3'd5
  } led_e;

  typedef struct packed {
    logic [CfgW-1:0] speed_low;
    logic [CfgW-1:0] speed_mid;
    logic [CfgW-1:0] speed_high;
    logic [CfgW-1:0] turn_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] left_x;
    logic [7:0] left_y;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic       pad_linked;
  } in_t;

  typedef struct packed {
    logic       serial_mode;
    logic       motors_off;
    logic       drive_ready;
    logic       coasting;
    logic       braking;
    logic       brake_reset_pulse;
    logic       brake_drive_pulse;
    logic       coast_pulse;
    logic [2:0] led_command;
    logic [1:0] gear;
  } status_t;

  typedef struct packed {
    logic signed [15:0] forward_velocity;
    logic signed [15:0] turn_velocity;
    status_t            status;
  } out_t;

  // Hand-off from the mode stage to the scale stage
  typedef struct packed {
    status_t         status;
    logic            upd;       // sticks rewrite both commands
    logic            zero;      // brake clears both commands
    logic [MagW-1:0] spd_mag;
    logic            spd_neg;
    logic            spd_div127;
    logic [MagW-1:0] trn_mag;
    logic            trn_neg;
    logic            trn_div127;
  } mode_t;

endpackage

// ===== hdl/gdc_if.sv =====
`timescale 1ns / 1ps

// Poll channel
interface gdc_in_if;
  logic          valid;
  logic          ready;
  gdc_pkg::in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// Command channel
interface gdc_out_if;
  logic          valid;
  logic          ready;
  gdc_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/gdc_mode.sv =====
`timescale 1ns / 1ps

// Gear stepping, mode rules and stick magnitudes for one poll.
// Mode state advances when step_i is high.
module gdc_mode (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  gdc_pkg::in_t   poll_i,
  input  gdc_pkg::cfg_t  cfg_i,
  output gdc_pkg::mode_t mode_o
);

  logic       serial_q, serial_d;
  logic       disabled_q, disabled_d;
  logic       ready_q, ready_d;
  logic       coast_q, coast_d;
  logic       brake_q, brake_d;
  logic [1:0] gear_q, gear_d;
  logic       latch_q, latch_d;

  logic       brk_rst, coast_p, active, upd;
  gdc_pkg::led_e led;
  logic [gdc_pkg::CfgW-1:0] vmax;
  logic [7:0] key, lx, ly, rx, ry;
  logic [7:0] dly, drx;
  logic       sig_full, sig_mid;

  assign key = poll_i.key_code;
  assign lx  = poll_i.left_x;
  assign ly  = poll_i.left_y;
  assign rx  = poll_i.right_x;
  assign ry  = poll_i.right_y;

  assign sig_full = (ly == gdc_pkg::STICK_FULL) && (lx == gdc_pkg::STICK_FULL) &&
                    (rx == gdc_pkg::STICK_FULL) && (ry == gdc_pkg::STICK_FULL);
  assign sig_mid  = (ly == gdc_pkg::STICK_MID) && (lx == gdc_pkg::STICK_MID) &&
                    (rx == gdc_pkg::STICK_MID) && (ry == gdc_pkg::STICK_MID);

  // Gear and mode rules; later rules override earlier ones
  always_comb begin
    gear_d     = gear_q;
    latch_d    = latch_q;
    serial_d   = serial_q;
    disabled_d = disabled_q;
    ready_d    = ready_q;
    coast_d    = coast_q;
    brake_d    = brake_q;
    brk_rst    = 1'b0;
    coast_p    = 1'b0;
    led        = gdc_pkg::LED_NONE;

    if (key == gdc_pkg::KEY_GEAR_UP && !latch_q) begin
      if (gear_q < gdc_pkg::GEAR_MAX) gear_d = gear_q + 2'd1;
      latch_d = 1'b1;
    end
    if (key == gdc_pkg::KEY_GEAR_DOWN && !latch_q) begin
      if (gear_q > gdc_pkg::GEAR_MIN) gear_d = gear_q - 2'd1;
      latch_d = 1'b1;
    end
    if (key == gdc_pkg::KEY_NONE) latch_d = 1'b0;

    if (key == gdc_pkg::KEY_SERIAL) begin
      serial_d = 1'b1;
      led      = gdc_pkg::LED_SERIAL_BLINK;
    end
    if (key == gdc_pkg::KEY_PAD) begin
      serial_d = 1'b0;
      led      = gdc_pkg::LED_PAD_BLINK;
    end
    if (key == gdc_pkg::KEY_ENABLE && ly == gdc_pkg::LEFT_CENTER &&
        rx == gdc_pkg::RIGHT_CENTER) begin
      disabled_d = 1'b0;
      ready_d    = 1'b1;
      coast_d    = 1'b0;
      brake_d    = 1'b0;
      led        = gdc_pkg::LED_GREEN;
    end
    if (key == gdc_pkg::KEY_SHUTDOWN || sig_full || sig_mid) begin
      serial_d   = 1'b0;
      brake_d    = 1'b0;
      disabled_d = 1'b1;
      ready_d    = 1'b0;
      coast_d    = 1'b1;
      coast_p    = 1'b1;
      led        = gdc_pkg::LED_RED;
    end
    if (key == gdc_pkg::KEY_BRAKE) begin
      serial_d   = 1'b0;
      disabled_d = 1'b0;
      ready_d    = 1'b0;
      coast_d    = 1'b0;
      if (!brake_d) begin
        brake_d = 1'b1;
        brk_rst = 1'b1;
      end
      led = gdc_pkg::LED_PINK;
    end
  end

  // Forward limit of the new gear
  always_comb begin
    unique case (gear_d)
      gdc_pkg::GEAR_MIN: vmax = cfg_i.speed_low;
      gdc_pkg::GEAR_MID: vmax = cfg_i.speed_mid;
      default:           vmax = cfg_i.speed_high;
    endcase
  end

  // A linked pad counts as active outside the dead band or with any key held
  assign active = poll_i.pad_linked &&
                  (ly < gdc_pkg::LEFT_DB_LO  || ly > gdc_pkg::LEFT_DB_HI  ||
                   rx < gdc_pkg::RIGHT_DB_LO || rx > gdc_pkg::RIGHT_DB_HI ||
                   lx < gdc_pkg::LEFT_DB_LO  || lx > gdc_pkg::LEFT_DB_HI  ||
                   ry < gdc_pkg::RIGHT_DB_LO || ry > gdc_pkg::RIGHT_DB_HI ||
                   key != gdc_pkg::KEY_NONE);
  assign upd = (!serial_d || active) && ready_d && !disabled_d;

  // Stick offsets as magnitude and sign; low left_y means forward
  assign dly = (ly >= gdc_pkg::LEFT_CENTER)  ? ly - gdc_pkg::LEFT_CENTER
                                             : gdc_pkg::LEFT_CENTER - ly;
  assign drx = (rx >= gdc_pkg::RIGHT_CENTER) ? rx - gdc_pkg::RIGHT_CENTER
                                             : gdc_pkg::RIGHT_CENTER - rx;

  always_comb begin
    mode_o.status.serial_mode       = serial_d;
    mode_o.status.motors_off        = disabled_d;
    mode_o.status.drive_ready       = ready_d;
    mode_o.status.coasting          = coast_d;
    mode_o.status.braking           = brake_d;
    mode_o.status.brake_reset_pulse = brk_rst;
    mode_o.status.brake_drive_pulse = (key == gdc_pkg::KEY_BRAKE);
    mode_o.status.coast_pulse       = coast_p;
    mode_o.status.led_command       = led;
    mode_o.status.gear              = gear_d;
    mode_o.upd        = upd;
    mode_o.zero       = (key == gdc_pkg::KEY_BRAKE);
    mode_o.spd_mag    = gdc_pkg::MagW'(vmax) * gdc_pkg::MagW'(dly);
    mode_o.spd_neg    = (ly > gdc_pkg::LEFT_CENTER);
    mode_o.spd_div127 = (ly > gdc_pkg::LEFT_CENTER);
    mode_o.trn_mag    = gdc_pkg::MagW'(cfg_i.turn_limit) * gdc_pkg::MagW'(drx);
    mode_o.trn_neg    = (rx > gdc_pkg::RIGHT_CENTER);
    mode_o.trn_div127 = (rx <= gdc_pkg::RIGHT_CENTER);
  end

  // Mode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      serial_q   <= 1'b0;
      disabled_q <= 1'b1;
      ready_q    <= 1'b0;
      coast_q    <= 1'b0;
      brake_q    <= 1'b0;
      gear_q     <= gdc_pkg::GEAR_MIN;
      latch_q    <= 1'b0;
    end else if (step_i) begin
      serial_q   <= serial_d;
      disabled_q <= disabled_d;
      ready_q    <= ready_d;
      coast_q    <= coast_d;
      brake_q    <= brake_d;
      gear_q     <= gear_d;
      latch_q    <= latch_d;
    end
  end

endmodule

// ===== hdl/gdc_scale.sv =====
`timescale 1ns / 1ps

// Divides the scaled stick magnitudes, truncating toward zero, and
// picks the next speed and turn commands.
module gdc_scale (
  input  gdc_pkg::mode_t     mode_i,
  input  logic signed [15:0] fwd_i,
  input  logic signed [15:0] turn_i,
  output logic signed [15:0] fwd_o,
  output logic signed [15:0] turn_o
);

  // Magnitude over 128 or 127; it never exceeds the limit that scaled it,
  // so the clamp to the limit is always satisfied.
  function automatic logic signed [15:0] scale_div(
    input logic [gdc_pkg::MagW-1:0] mag,
    input logic                     div127,
    input logic                     neg
  );
    logic [gdc_pkg::MagW+gdc_pkg::RecipW-1:0] prod;
    logic [14:0]                              quot;
    prod = (gdc_pkg::MagW + gdc_pkg::RecipW)'(mag) *
           (gdc_pkg::MagW + gdc_pkg::RecipW)'(gdc_pkg::RECIP127);
    quot = div127 ? prod[gdc_pkg::RECIP_SHIFT +: 15] : mag[7 +: 15];
    return neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  endfunction

  logic signed [15:0] fwd_new, turn_new;

  assign fwd_new  = scale_div(mode_i.spd_mag, mode_i.spd_div127, mode_i.spd_neg);
  assign turn_new = scale_div(mode_i.trn_mag, mode_i.trn_div127, mode_i.trn_neg);

  // Stick update wins; a brake without update clears; otherwise hold
  always_comb begin
    priority if (mode_i.upd) begin
      fwd_o  = fwd_new;
      turn_o = turn_new;
    end else if (mode_i.zero) begin
      fwd_o  = '0;
      turn_o = '0;
    end else begin
      fwd_o  = fwd_i;
      turn_o = turn_i;
    end
  end

endmodule

// ===== hdl/gamepad_drive_command.sv =====
`timescale 1ns / 1ps
// Gamepad drive command block.
// Poll channel in_i (valid/ready) carries one gamepad poll per transfer:
// key code, four stick bytes and the pad-linked flag. Command channel out_o
// returns exactly one result per poll, in order: Q8.8 forward and turn
// commands, mode flags, brake/coast pulses, LED command and gear.
// Speed limits and the turn limit are written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i; the user must write them only while the block is idle, the block does not enforce it.
// Throughput: one poll per cycle while out_o.ready is high. A result passes
// through the input register, then the mode stage with the limit multiply,
// then the scale stage with the reciprocal multiply for the /127 case into
// the result register.
// Mode state advances as a poll leaves the input register; the commands are
// held in the result register, updated as a poll enters it.
// Reset: motors disabled, pad mode, gear 0, commands zero, limits at their
// defaults, all stages empty.
// When the receiver stalls, the result holds and the stages behind it fill;
// in_i.ready drops only once all three are occupied, nothing is dropped.
`include "assert_macros.svh"

module gamepad_drive_command (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  gdc_in_if.sink                       in_i,
  gdc_out_if.source                    out_o,
  input  logic                         cfg_we_i,
  input  logic [gdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gdc_pkg::CfgW-1:0]     cfg_wdata_i
);

  gdc_pkg::cfg_t    cfg_q;
  logic             s1_v_q, s2_v_q, out_v_q;
  gdc_pkg::in_t     s1_q;
  gdc_pkg::mode_t   s2_q, mode;
  gdc_pkg::status_t status_q;
  logic signed [15:0] fwd_q, fwd_d, turn_q, turn_d;
  logic             s1_adv, out_adv, in_xfer;

  // Pipeline flow control
  assign out_adv = s2_v_q && (!out_v_q || out_o.ready);
  assign s1_adv  = s1_v_q && (!s2_v_q || out_adv);
  assign in_i.ready = !s1_v_q || s1_adv;
  assign in_xfer = in_i.valid && in_i.ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_low  <= gdc_pkg::SPEED_LOW_RST;
      cfg_q.speed_mid  <= gdc_pkg::SPEED_MID_RST;
      cfg_q.speed_high <= gdc_pkg::SPEED_HIGH_RST;
      cfg_q.turn_limit <= gdc_pkg::TURN_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (gdc_pkg::cfg_idx_e'(cfg_idx_i))
        gdc_pkg::CFG_SPEED_LOW:  cfg_q.speed_low  <= cfg_wdata_i;
        gdc_pkg::CFG_SPEED_MID:  cfg_q.speed_mid  <= cfg_wdata_i;
        gdc_pkg::CFG_SPEED_HIGH: cfg_q.speed_high <= cfg_wdata_i;
        gdc_pkg::CFG_TURN_LIMIT: cfg_q.turn_limit <= cfg_wdata_i;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_xfer)     s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (s1_adv)       s2_v_q <= 1'b1;
      else if (out_adv) s2_v_q <= 1'b0;
      if (out_adv)          out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_q <= in_i.data;
    if (s1_adv)  s2_q <= mode;
    if (out_adv) status_q <= s2_q.status;
  end

  // Held speed and turn commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= '0;
      turn_q <= '0;
    end else if (out_adv) begin
      fwd_q  <= fwd_d;
      turn_q <= turn_d;
    end
  end

  gdc_mode u_mode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .poll_i (s1_q),
    .cfg_i  (cfg_q),
    .mode_o (mode)
  );

  gdc_scale u_scale (
    .mode_i (s2_q),
    .fwd_i  (fwd_q),
    .turn_i (turn_q),
    .fwd_o  (fwd_d),
    .turn_o (turn_d)
  );

  assign out_o.valid                 = out_v_q;
  assign out_o.data.forward_velocity = fwd_q;
  assign out_o.data.turn_velocity    = turn_q;
  assign out_o.data.status           = status_q;

  // Checks
  `GDC_ASSERT(a_rst_pulse_drive, clk_i, rst_ni, !out_v_q || !status_q.brake_reset_pulse || status_q.brake_drive_pulse, "brake reset pulse without brake drive pulse")
  `GDC_ASSERT(a_ready_enabled, clk_i, rst_ni, !out_v_q || !(status_q.drive_ready && status_q.motors_off), "drive ready while motors are off")
  `GDC_ASSERT(a_coast_flags, clk_i, rst_ni, !out_v_q || !status_q.coast_pulse || status_q.brake_drive_pulse || (status_q.coasting && status_q.motors_off), "coast pulse without coasting shutdown")
  `GDC_ASSERT_NEXT(a_brake_zero, clk_i, rst_ni, out_adv && s2_q.zero && !s2_q.upd, fwd_q == 16'sd0 && turn_q == 16'sd0, "brake did not clear commands")

endmodule
